### src/ddd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control store for the date difference unit.
// No dependencies; used by every other file of the block.
package ddd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int ACC_W   = DIFF_W + 2;  // day-number difference plus headroom
  localparam int QUO_W   = 8;           // largest year / 100 fits here
  localparam int PROD_W  = 27;
  localparam int MUL_B_W = 13;
  localparam int LOW_W   = 13;
  localparam int HUND_W  = YEAR_W + 1;

  localparam int MAX_YEAR_DEF = 9999;
  localparam int RECIP_100    = 5243;   // ceil(2^19 / 100), exact for 14-bit years
  localparam int RECIP_SHIFT  = 19;
  localparam int DAYS_YEAR    = 365;
  localparam int MONTHS       = 12;
  localparam int FEB          = 2;
  localparam int DIFF_MAX     = 2 ** (DIFF_W - 1) - 1;
  localparam int DIFF_MIN     = -(2 ** (DIFF_W - 1));

  localparam int STEP_W    = 4;
  localparam int STEP_LAST = 8;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               inclusive;
  } req_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     date_error;
  } res_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_Y100, MUL_P100, MUL_P365} mul_op_t;
  typedef enum logic {SIDE_START, SIDE_END} side_t;
  typedef enum logic [1:0] {LAT_NONE, LAT_LEAP, LAT_QP} latch_t;
  typedef enum logic [1:0] {TERM_NONE, TERM_LOW, TERM_CENT, TERM_PROD} term_t;
  typedef enum logic {COND_NONE, COND_ERR} cond_t;

  typedef struct packed {
    mul_op_t           mul_op;
    side_t             mul_side;
    latch_t            latch;
    side_t             latch_side;
    logic              acc_clr;
    logic              acc_sub;
    term_t             term;
    side_t             term_side;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  function automatic ctrl_t ctrl_nop();
    ctrl_t c;
    c.mul_op     = MUL_NONE;
    c.mul_side   = SIDE_START;
    c.latch      = LAT_NONE;
    c.latch_side = SIDE_START;
    c.acc_clr    = 1'b0;
    c.acc_sub    = 1'b0;
    c.term       = TERM_NONE;
    c.term_side  = SIDE_START;
    c.cond       = COND_NONE;
    c.target     = '0;
    c.last       = 1'b0;
    return c;
  endfunction

  // Microprogram. Quotients and products are registered and used in the step after the one that issues them.
  function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = ctrl_nop();
    unique case (step)
      4'd0: begin
        c.mul_op = MUL_Y100; c.mul_side = SIDE_START;
      end
      4'd1: begin
        c.latch  = LAT_LEAP; c.latch_side = SIDE_START;
        c.mul_op = MUL_Y100; c.mul_side   = SIDE_END;
      end
      4'd2: begin
        c.latch   = LAT_LEAP; c.latch_side = SIDE_END;
        c.mul_op  = MUL_P100; c.mul_side   = SIDE_START;
        c.acc_clr = 1'b1; c.acc_sub = 1'b1;
        c.term    = TERM_LOW; c.term_side  = SIDE_START;
      end
      4'd3: begin
        c.cond   = COND_ERR; c.target = STEP_W'(STEP_LAST);
        c.latch  = LAT_QP;   c.latch_side = SIDE_START;
        c.mul_op = MUL_P100; c.mul_side   = SIDE_END;
        c.term   = TERM_LOW; c.term_side  = SIDE_END;
      end
      4'd4: begin
        c.latch   = LAT_QP;   c.latch_side = SIDE_END;
        c.mul_op  = MUL_P365; c.mul_side   = SIDE_START;
        c.acc_sub = 1'b1;
        c.term    = TERM_CENT; c.term_side = SIDE_START;
      end
      4'd5: begin
        c.mul_op  = MUL_P365; c.mul_side = SIDE_END;
        c.acc_sub = 1'b1;
        c.term    = TERM_PROD;
      end
      4'd6: begin
        c.term = TERM_PROD;
      end
      4'd7: begin
        c.term = TERM_CENT; c.term_side = SIDE_END;
      end
      4'd8: begin
        c.last = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### src/ddd_seq.sv
`timescale 1ns / 1ps
// Step counter and control store walk for the date difference unit.
// Depends on ddd_pkg for the control word and the microprogram.
module ddd_seq import ddd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  err,
  output logic  busy,
  output ctrl_t ctrl
);

  logic              run;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             word;

  always_comb begin
    word = prog_word(step);
    if (word.cond == COND_ERR && err) begin
      step_next = word.target;
    end else begin
      step_next = step + 1'b1;
    end
    ctrl = run ? word : ctrl_nop();
  end

  assign busy = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
    end else if (!run) begin
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end
    end else if (word.last) begin
      run <= 1'b0;
    end else begin
      step <= step_next;
    end
  end

endmodule

### src/date_difference_days_unit.sv
`timescale 1ns / 1ps
// Gregorian date difference: signed days from start to end date, with error flag.
// The nine microprogram steps share one multiplier, issued at most once per step.
// The unit takes no new item while busy; a new item may be started in the
// cycle that shows done. Invalid dates leave the program early at step three.
// Reset (rst, synchronous) idles the sequencer and drops done; the receiver
// cannot stall, and done is high for one cycle only. Uses ddd_pkg, ddd_seq.
module date_difference_days_unit import ddd_pkg::*; #(
  parameter int MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  localparam logic [15:0] MaxYearW = 16'(MAX_YEAR);

  // Item captured at accept
  req_t              req;
  // Shared constant multiplier, product registered
  logic [PROD_W-1:0] prod;
  // Per-date leap flags and (year-1)/100
  logic              leap_s, leap_e;
  logic [QUO_W-1:0]  qp_s, qp_e;
  // Running day-number difference
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  ctrl_t ctrl;
  logic  accept;
  logic  err;

  assign accept = start && !busy;

  ddd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .err   (err),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
  end

  // Side selection helpers
  function automatic logic [YEAR_W-1:0] year_of(input req_t r, input side_t s);
    return (s == SIDE_END) ? r.end_year : r.start_year;
  endfunction

  function automatic logic date_ok(input logic [YEAR_W-1:0] y,
                                   input logic [MONTH_W-1:0] m,
                                   input logic [DAY_W-1:0] d,
                                   input logic leap);
    logic y_ok, m_ok, d_ok;
    y_ok = (y != '0) && (16'(y) <= MaxYearW);
    m_ok = (m != '0) && (m <= MONTH_W'(MONTHS));
    d_ok = (d != '0) && (d <= month_len(m, leap));
    return y_ok && m_ok && d_ok;
  endfunction

  assign err = !date_ok(req.start_year, req.start_month, req.start_day, leap_s) ||
               !date_ok(req.end_year, req.end_month, req.end_day, leap_e);

  // Multiplier: year/100 or (year-1)/100 by reciprocal, or (year-1)*365
  logic [YEAR_W-1:0]  mul_year;
  logic [YEAR_W-1:0]  mul_a;
  logic [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_year = year_of(req, ctrl.mul_side);
    unique case (ctrl.mul_op)
      MUL_Y100: mul_a = mul_year;
      MUL_P100: mul_a = mul_year - 1'b1;
      MUL_P365: mul_a = mul_year - 1'b1;
      default:  mul_a = '0;
    endcase
    mul_b = (ctrl.mul_op == MUL_P365) ? MUL_B_W'(DAYS_YEAR) : MUL_B_W'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != MUL_NONE) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Leap test from the quotient: a century is leap only when y/100 is a multiple of 4
  logic [QUO_W-1:0]  quo;
  logic [YEAR_W-1:0] lat_year;
  logic [HUND_W-1:0] hund;
  logic              leap_calc;

  always_comb begin
    quo       = prod[RECIP_SHIFT +: QUO_W];
    lat_year  = year_of(req, ctrl.latch_side);
    hund      = (HUND_W'(quo) << 6) + (HUND_W'(quo) << 5) + (HUND_W'(quo) << 2);
    leap_calc = (HUND_W'(lat_year) == hund) ? (quo[1:0] == 2'b00)
                                            : (lat_year[1:0] == 2'b00);
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.latch)
      LAT_LEAP: begin
        if (ctrl.latch_side == SIDE_END) leap_e <= leap_calc;
        else                             leap_s <= leap_calc;
      end
      LAT_QP: begin
        if (ctrl.latch_side == SIDE_END) qp_e <= quo;
        else                             qp_s <= quo;
      end
      default: begin
      end
    endcase
  end

  // Accumulator terms: low part (p/4 + month offset + day + leap day) and
  // century part (p/400 - p/100), plus the registered product.
  logic [YEAR_W-1:0]       t_year, t_p;
  logic [MONTH_W-1:0]      t_month;
  logic [DAY_W-1:0]        t_day;
  logic                    t_leap;
  logic [QUO_W-1:0]        t_qp;
  logic [LOW_W-1:0]        low;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_base;

  always_comb begin
    t_year  = year_of(req, ctrl.term_side);
    t_p     = t_year - 1'b1;
    t_month = (ctrl.term_side == SIDE_END) ? req.end_month : req.start_month;
    t_day   = (ctrl.term_side == SIDE_END) ? req.end_day : req.start_day;
    t_leap  = (ctrl.term_side == SIDE_END) ? leap_e : leap_s;
    t_qp    = (ctrl.term_side == SIDE_END) ? qp_e : qp_s;
    low     = LOW_W'(t_p >> 2) + LOW_W'(days_before(t_month)) + LOW_W'(t_day)
            + LOW_W'((t_month > MONTH_W'(FEB)) && t_leap);
    unique case (ctrl.term)
      TERM_LOW:  term = ACC_W'(low);
      TERM_CENT: term = ACC_W'(t_qp >> 2) - ACC_W'(t_qp);
      TERM_PROD: term = ACC_W'(prod);
      default:   term = '0;
    endcase
    acc_base = ctrl.acc_clr ? '0 : acc;
    acc_next = ctrl.acc_sub ? acc_base - term : acc_base + term;
  end

  always_ff @(posedge clk) begin
    if (ctrl.term != TERM_NONE || ctrl.acc_clr) begin
      acc <= acc_next;
    end
  end

  // Final step: inclusive adjust, clamp to the result width, error forces zero
  logic signed [ACC_W-1:0]  adj;
  logic signed [DIFF_W-1:0] sat;

  always_comb begin
    if (req.inclusive) begin
      adj = acc[ACC_W-1] ? acc - ACC_W'(1) : acc + ACC_W'(1);
    end else begin
      adj = acc;
    end
    priority if (adj > ACC_W'(DIFF_MAX)) begin
      sat = DIFF_W'(DIFF_MAX);
    end else if (adj < ACC_W'(DIFF_MIN)) begin
      sat = DIFF_W'(DIFF_MIN);
    end else begin
      sat = adj[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.last) begin
      result.day_difference <= err ? '0 : sat;
      result.date_error     <= err;
    end
  end

endmodule

### src/ddd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the date difference unit, bound to the top level.
// Depends on ddd_pkg for the item types.
module ddd_checker import ddd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t request,
  input logic busy,
  input logic done,
  input res_t result
);

  // Result strobe comes with the unit already free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // Accepted item always starts a run
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  // An error result carries a zero difference
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.date_error) |-> (result.day_difference == '0))
    else $error("error result with nonzero difference");

  // At most one strobe per run
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

endmodule

bind date_difference_days_unit ddd_checker u_ddd_checker (.*);

### dv/tb_date_difference_days_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for date_difference_days_unit: directed table, then random date queries.
// Expected results come from a local day-count model; needs ddd_pkg and the unit RTL.
module tb_date_difference_days_unit;
  import ddd_pkg::*;

  localparam int TB_MAX_YEAR  = 9999;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 3;
  // Nothing accepted on either side for this long means the unit has hung.
  // The longest sender gap at 78 % idle is far below this.
  localparam int QUIET_LIMIT  = 5000;
  // Settle time after the last result, a little over one item's latency.
  localparam int DRAIN_CYCLES = 12;
  localparam int REQ_BITS     = $bits(req_t);
  localparam int MAX_SHOWN    = 10;

  // One row of the directed table. Where known is set the expected result is
  // typed in; otherwise it comes from the day-count model.
  typedef struct {
    req_t req;
    bit   known;
    res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  res_t result;

  // Typed expectation travelling alongside the request it belongs to.
  logic typed_valid = 1'b0;
  res_t typed_res = '0;

  res_t gap_queue[$];     // expected results, oldest first
  int   fail_count = 0;
  int   quiet_cycles = 0;

  date_difference_days_unit #(.MAX_YEAR(TB_MAX_YEAR)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Day-count model
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year, but centuries only when divisible by 400.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Length of month m (1..12) in year y.
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic bit valid_date(input int unsigned y, input int unsigned m,
                                    input int unsigned d);
    if (y < 1 || y > TB_MAX_YEAR) return 1'b0;
    if (m < 1 || m > MONTHS) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Serial day number, 0001-01-01 being day 1. Only called on valid dates.
  function automatic longint serial_day(input int unsigned y, input int unsigned m,
                                        input int unsigned d);
    longint      n;
    int unsigned p;
    p = y - 1;
    n = longint'(p) * DAYS_YEAR + p / 4 - p / 100 + p / 400;
    // Months before m, counted in a common year; the leap day is added below.
    for (int unsigned k = 1; k < m; k++) n += month_days(k, 1);
    if (m > FEB && leap_year(y)) n += 1;
    return n + d;
  endfunction

  // Expected result for one query.
  function automatic res_t date_gap(input req_t q);
    res_t   r;
    longint d;
    r = '0;
    if (!valid_date(q.start_year, q.start_month, q.start_day) ||
        !valid_date(q.end_year, q.end_month, q.end_day)) begin
      // Either date bad: flag it, difference forced to zero.
      r.date_error = 1'b1;
      return r;
    end
    d = serial_day(q.end_year, q.end_month, q.end_day) -
        serial_day(q.start_year, q.start_month, q.start_day);
    // Inclusive count grows the magnitude, so the sign decides the direction.
    if (q.inclusive) d = (d >= 0) ? d + 1 : d - 1;
    if (d > DIFF_MAX) d = DIFF_MAX;
    if (d < DIFF_MIN) d = DIFF_MIN;
    r.day_difference = DIFF_W'(d);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t row(input int sy, input int sm, input int sd,
                                   input int ey, input int em, input int ed,
                                   input bit inc, input bit known,
                                   input int diff, input bit err);
    dir_row_t t;
    t.req.start_year          = YEAR_W'(sy);
    t.req.start_month         = MONTH_W'(sm);
    t.req.start_day           = DAY_W'(sd);
    t.req.end_year            = YEAR_W'(ey);
    t.req.end_month           = MONTH_W'(em);
    t.req.end_day             = DAY_W'(ed);
    t.req.inclusive           = inc;
    t.known                   = known;
    t.want.day_difference     = DIFF_W'(diff);
    t.want.date_error         = err;
    return t;
  endfunction

  function automatic req_t noise_query();
    return req_t'(REQ_BITS'({$urandom(), $urandom()}));
  endfunction

  // Month outside 1..12.
  function automatic logic [MONTH_W-1:0] bad_month();
    int unsigned k;
    k = $urandom_range(3);
    return (k == 0) ? MONTH_W'(0) : MONTH_W'(MONTHS + k);
  endfunction

  // Day 0, or a day past the end of the month where the month allows one.
  function automatic logic [DAY_W-1:0] bad_day(input int unsigned m, input int unsigned y);
    int unsigned len;
    len = month_days(m, y);
    if (len == 31 || $urandom_range(3) == 0) return DAY_W'(0);
    return DAY_W'($urandom_range(31, len + 1));
  endfunction

  // Year 0, or one past the top of the range, up to all ones.
  function automatic logic [YEAR_W-1:0] bad_year();
    if ($urandom_range(1)) return YEAR_W'(0);
    return YEAR_W'($urandom_range((1 << YEAR_W) - 1, TB_MAX_YEAR + 1));
  endfunction

  // Mostly two well-formed dates (often close together, so that day and month
  // borrows get exercised), some with one field broken, the rest raw noise.
  function automatic req_t random_query();
    req_t        q;
    int unsigned pick;
    int          ny;
    pick = $urandom_range(99);
    if (pick >= 90) return noise_query();
    q.start_year = YEAR_W'($urandom_range(TB_MAX_YEAR, 1));
    if ($urandom_range(1)) begin
      q.end_year = YEAR_W'($urandom_range(TB_MAX_YEAR, 1));
    end else begin
      ny = int'(q.start_year) + int'($urandom_range(4)) - 2;
      if (ny < 1) ny = 1;
      if (ny > TB_MAX_YEAR) ny = TB_MAX_YEAR;
      q.end_year = YEAR_W'(ny);
    end
    q.start_month = MONTH_W'($urandom_range(MONTHS, 1));
    q.end_month   = MONTH_W'($urandom_range(MONTHS, 1));
    q.start_day   = DAY_W'($urandom_range(month_days(q.start_month, q.start_year), 1));
    q.end_day     = DAY_W'($urandom_range(month_days(q.end_month, q.end_year), 1));
    q.inclusive   = 1'($urandom_range(1));
    if (pick >= 80) begin
      case ($urandom_range(5))
        0:       q.start_month = bad_month();
        1:       q.end_month   = bad_month();
        2:       q.start_day   = bad_day(q.start_month, q.start_year);
        3:       q.end_day     = bad_day(q.end_month, q.end_year);
        4:       q.start_year  = bad_year();
        default: q.end_year    = bad_year();
      endcase
    end
    return q;
  endfunction

  task automatic note_fail(input string msg);
    if (fail_count < MAX_SHOWN) $display("%s", msg);
    fail_count++;
  endtask

  // Called at a falling edge. Idles the requester for a random stretch, then
  // holds start until the unit takes the item, and returns at the falling
  // edge after acceptance with start still high, so that a back-to-back item
  // needs only one assignment in that step.
  task automatic send_query(input req_t q, input bit known, input res_t want,
                            input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      request <= noise_query();   // must be ignored while start is low
      @(negedge clk);
    end
    start       <= 1'b1;
    request     <= q;
    typed_valid <= known;
    typed_res   <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog, all at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      // Result strobe first: results are checked in order against the queue.
      if (done) begin
        if (gap_queue.size() == 0) begin
          note_fail($sformatf("unexpected result: diff=%0d err=%0b",
                              result.day_difference, result.date_error));
        end else begin
          want = gap_queue.pop_front();
          if (result.day_difference !== want.day_difference ||
              result.date_error !== want.date_error) begin
            note_fail($sformatf("mismatch: expected diff=%0d err=%0b, got diff=%0d err=%0b",
                                want.day_difference, want.date_error,
                                result.day_difference, result.date_error));
          end
        end
      end
      // Item taken at this edge: queue what it should produce.
      if (start && !busy) begin
        gap_queue.push_back(typed_valid ? typed_res : date_gap(request));
      end
      if (done || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t rows[$];
    int       idle_pct;
    res_t     none;
    none = '0;

    // Same date, both ways of counting.
    rows.push_back(row(2024, 1, 1, 2024, 1, 1, 0, 1, 0, 0));
    rows.push_back(row(2024, 1, 1, 2024, 1, 1, 1, 1, 1, 0));
    // Full span of the year range, forwards and backwards.
    rows.push_back(row(1, 1, 1, 9999, 12, 31, 0, 1, 3652058, 0));
    rows.push_back(row(1, 1, 1, 9999, 12, 31, 1, 1, 3652059, 0));
    rows.push_back(row(9999, 12, 31, 1, 1, 1, 0, 1, -3652058, 0));
    rows.push_back(row(9999, 12, 31, 1, 1, 1, 1, 1, -3652059, 0));
    // Leap days: ordinary leap year, 400-year century, non-leap century, common year.
    rows.push_back(row(2024, 2, 29, 2024, 3, 1, 0, 0, 0, 0));
    rows.push_back(row(2000, 2, 29, 1900, 2, 28, 1, 0, 0, 0));
    rows.push_back(row(1900, 2, 29, 1900, 3, 1, 0, 1, 0, 1));
    rows.push_back(row(2023, 2, 29, 2023, 3, 1, 0, 1, 0, 1));
    // End day below start day, across a short month.
    rows.push_back(row(2023, 1, 31, 2023, 3, 1, 0, 0, 0, 0));
    rows.push_back(row(2023, 5, 20, 2024, 4, 3, 1, 0, 0, 0));
    // Bad months on either side and bad start days, then a valid pair of month ends.
    rows.push_back(row(2020, 0, 10, 2020, 1, 1, 0, 1, 0, 1));
    rows.push_back(row(2020, 1, 1, 2020, 13, 1, 1, 1, 0, 1));
    rows.push_back(row(2020, 15, 31, 2020, 1, 1, 0, 1, 0, 1));
    rows.push_back(row(2020, 4, 31, 2020, 5, 1, 0, 1, 0, 1));
    rows.push_back(row(2020, 1, 0, 2020, 1, 1, 1, 1, 0, 1));
    rows.push_back(row(2020, 1, 31, 2020, 12, 31, 0, 0, 0, 0));
    // Years out of range.
    rows.push_back(row(0, 1, 1, 2020, 1, 1, 0, 1, 0, 1));
    rows.push_back(row(2020, 1, 1, 10000, 1, 1, 0, 1, 0, 1));
    // All ones and all zeros.
    rows.push_back(row(16383, 15, 31, 16383, 15, 31, 1, 1, 0, 1));
    rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
    // Century boundary, and the year bit 13 turning on.
    rows.push_back(row(1899, 12, 31, 1900, 3, 1, 1, 0, 0, 0));
    rows.push_back(row(8191, 7, 15, 8192, 8, 16, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_query(rows[i].req, rows[i].known, rows[i].want, 0);

    // Random part in three idling phases: none, heavy, light.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 1) ? 78 : 7;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_query(random_query(), 1'b0, none, idle_pct);
      end
    end
    start <= 1'b0;

    // Drain: the watchdog covers a result that never comes.
    while (gap_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gap_queue.size() != 0) note_fail("results still outstanding at end of run");

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
